/* design/cpg_pkg.sv */
// Shared constants and types for the circle point generator.
`timescale 1ns / 1ps
package cpg_pkg;

  localparam int unsigned CoordWidth = 11;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PointsPerStep = 8;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_e;

endpackage

/* design/cpg_if.sv */
// Request and point channel interfaces of the circle point generator.
`timescale 1ns / 1ps
interface cpg_req_if #(
  parameter int unsigned CW = 11
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;
  logic [CW-2:0] radius;

  modport source (output valid, req_type, center_x, center_y, radius, input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

interface cpg_pt_if #(
  parameter int unsigned CW = 11
);
  logic                 valid;
  logic                 ready;
  logic signed [CW+1:0] point_x;
  logic signed [CW+1:0] point_y;
  logic                 last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

/* design/cpg_fifo.sv */
// Small first-in first-out queue of step descriptors between front and back.
`timescale 1ns / 1ps
module cpg_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

/* design/cpg_front.sv */
// Request front end: holds the circle state, steps the decision and queues each step.
`timescale 1ns / 1ps
module cpg_front #(
  parameter int unsigned CW = cpg_pkg::CoordWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cpg_req_if.sink         req,
  input  logic            full_i,
  output logic            push_o,
  output logic [4*CW:0]   batch_o
);
  import cpg_pkg::*;

  localparam int unsigned DW = CW + 3;

  logic [CW-1:0]        cx_q, cy_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [DW-1:0] d_q;
  logic                 active_q;

  logic [CW-1:0]        cur_cx, cur_cy;
  logic signed [CW-1:0] cur_x, cur_y;
  logic signed [DW-1:0] cur_d, x_ext, y_ext, r_ext;
  logic signed [CW-1:0] x_d, y_d;
  logic signed [DW-1:0] d_d;
  logic                 is_start, accept, last;

  assign req.ready = !full_i;
  assign accept    = req.valid && req.ready;
  assign is_start  = (req_type_e'(req.req_type) == REQ_START);
  assign push_o    = accept && (is_start || active_q);

  always_comb begin
    r_ext = {4'b0000, req.radius};
    if (is_start) begin
      cur_cx = req.center_x;
      cur_cy = req.center_y;
      cur_x  = '0;
      cur_y  = {1'b0, req.radius};
      cur_d  = DW'(3) - (r_ext <<< 1);
    end else begin
      cur_cx = cx_q;
      cur_cy = cy_q;
      cur_x  = x_q;
      cur_y  = y_q;
      cur_d  = d_q;
    end
    x_ext = {{3{cur_x[CW-1]}}, cur_x};
    y_ext = {{3{cur_y[CW-1]}}, cur_y};
    x_d   = cur_x + 1'b1;
    if (cur_d[DW-1]) begin
      d_d = cur_d + (x_ext <<< 2) + DW'(6);
      y_d = cur_y;
    end else begin
      d_d = cur_d + ((x_ext - y_ext) <<< 2) + DW'(10);
      y_d = cur_y - 1'b1;
    end
    last = (x_d > y_d);
  end

  assign batch_o = {last, cur_cx, cur_cy, cur_x, cur_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
    end else if (push_o) begin
      active_q <= !last;
      cx_q     <= cur_cx;
      cy_q     <= cur_cy;
      x_q      <= x_d;
      y_q      <= y_d;
      d_q      <= d_d;
    end
  end
endmodule

/* design/cpg_back.sv */
// Point back end: expands one queued step into eight mirrored points, one per transfer.
`timescale 1ns / 1ps
module cpg_back #(
  parameter int unsigned CW = cpg_pkg::CoordWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  logic [4*CW:0] batch_i,
  output logic          pop_o,
  cpg_pt_if.source      pt
);
  import cpg_pkg::*;

  localparam int unsigned IdxW = $clog2(PointsPerStep);

  logic [4*CW:0]        batch_q;
  logic                 busy_q;
  logic [IdxW-1:0]      idx_q;
  logic                 out_valid_q;
  logic signed [CW+1:0] px_q, py_q;
  logic                 last_q;

  logic                 b_last;
  logic [CW-1:0]        b_cx, b_cy, b_x, b_y;
  logic signed [CW+1:0] cx_e, cy_e, a_e, b_e, px_d, py_d;
  logic                 fire, final_pt;

  assign {b_last, b_cx, b_cy, b_x, b_y} = batch_q;

  assign fire     = busy_q && (!out_valid_q || pt.ready);
  assign final_pt = (idx_q == IdxW'(PointsPerStep - 1));
  assign pop_o    = avail_i && (!busy_q || (fire && final_pt));

  always_comb begin
    cx_e = {2'b00, b_cx};
    cy_e = {2'b00, b_cy};
    if (idx_q[2]) begin
      a_e = {{2{b_y[CW-1]}}, b_y};
      b_e = {{2{b_x[CW-1]}}, b_x};
    end else begin
      a_e = {{2{b_x[CW-1]}}, b_x};
      b_e = {{2{b_y[CW-1]}}, b_y};
    end
    px_d = idx_q[0] ? (cx_e - a_e) : (cx_e + a_e);
    py_d = idx_q[1] ? (cy_e - b_e) : (cy_e + b_e);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (fire && final_pt) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        idx_q       <= idx_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pt.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      batch_q <= batch_i;
    end
    if (fire) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= b_last && final_pt;
    end
  end

  assign pt.valid      = out_valid_q;
  assign pt.point_x    = px_q;
  assign pt.point_y    = py_q;
  assign pt.last_point = last_q;
endmodule

/* design/circle_point_generator.sv */
// Midpoint circle point generator: start and advance requests in, mirrored points out.
// The first point of a step passes the step queue, the step register and the point register.
// Each step gives eight points, one per cycle unless the point channel stalls.
// An advance with no circle running gives no points.
// A two-entry step queue lets requests be taken while points are still draining.
// Reset (asynchronous, active low) clears the circle state, the queue and the output.
`timescale 1ns / 1ps
module circle_point_generator #(
  parameter int unsigned COORD_WIDTH = cpg_pkg::CoordWidth,
  parameter int unsigned QUEUE_DEPTH = cpg_pkg::QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cpg_req_if.sink  req_i,
  cpg_pt_if.source pt_o
);
  import cpg_pkg::*;

  localparam int unsigned BatchW = 4 * COORD_WIDTH + 1;

  logic              push, full, pop, avail;
  logic [BatchW-1:0] batch_in, batch_out;

  cpg_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .full_i  (full),
    .push_o  (push),
    .batch_o (batch_in)
  );

  cpg_fifo #(.Width(BatchW), .Depth(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (batch_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (avail),
    .data_o  (batch_out)
  );

  cpg_back #(.CW(COORD_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .batch_i (batch_out),
    .pop_o   (pop),
    .pt      (pt_o)
  );
endmodule

/* test/circle_point_generator_test.sv */
// Self-checking testbench for the circle point generator: random and directed requests.
`timescale 1ns / 1ps
module circle_point_generator_test;
  import cpg_pkg::*;

  localparam int unsigned CW = CoordWidth;
  localparam int unsigned PW = CW + 2;
  localparam int unsigned StepTarget = 300;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic                 last;
  } point_t;

  class circle_scoreboard;
    point_t          pending[$];
    int unsigned     mismatches;
    logic [CW-1:0]   center_x;
    logic [CW-1:0]   center_y;
    int              off_x;
    int              off_y;
    int              decision;
    bit              running;

    function new();
      mismatches = 0;
      center_x = '0;
      center_y = '0;
      off_x = 0;
      off_y = 0;
      decision = 0;
      running = 1'b0;
    endfunction

    function point_t make_point(int px, int py);
      point_t p;
      p.x = PW'(px);
      p.y = PW'(py);
      p.last = 1'b0;
      return p;
    endfunction

    // Returns 1 when the request produces a step of eight points.
    function bit note_request(req_type_e kind, logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [CW-2:0] r);
      point_t step_pts[8];
      int     ux;
      int     uy;
      int     ox;
      int     oy;
      if (kind == REQ_START) begin
        center_x = cx;
        center_y = cy;
        off_x = 0;
        off_y = int'(r);
        decision = 3 - 2 * int'(r);
        running = 1'b1;
      end else if (!running) begin
        return 1'b0;
      end
      ux = int'(center_x);
      uy = int'(center_y);
      ox = off_x;
      oy = off_y;
      step_pts[0] = make_point(ux + ox, uy + oy);
      step_pts[1] = make_point(ux - ox, uy + oy);
      step_pts[2] = make_point(ux + ox, uy - oy);
      step_pts[3] = make_point(ux - ox, uy - oy);
      step_pts[4] = make_point(ux + oy, uy + ox);
      step_pts[5] = make_point(ux - oy, uy + ox);
      step_pts[6] = make_point(ux + oy, uy - ox);
      step_pts[7] = make_point(ux - oy, uy - ox);
      if (decision < 0) begin
        decision = decision + 4 * ox + 6;
      end else begin
        decision = decision + 4 * (ox - oy) + 10;
        off_y = oy - 1;
      end
      off_x = ox + 1;
      if (off_x > off_y) begin
        step_pts[7].last = 1'b1;
        running = 1'b0;
      end
      foreach (step_pts[i]) pending.push_back(step_pts[i]);
      return 1'b1;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_point(logic signed [PW-1:0] px, logic signed [PW-1:0] py, logic last);
      point_t exp_pt;
      if (pending.size() == 0) begin
        report($sformatf("unexpected point (%0d,%0d) last=%0b", px, py, last));
      end else begin
        exp_pt = pending.pop_front();
        if (px !== exp_pt.x || py !== exp_pt.y || last !== exp_pt.last) begin
          report($sformatf("point (%0d,%0d) last=%0b, expected (%0d,%0d) last=%0b",
                           px, py, last, exp_pt.x, exp_pt.y, exp_pt.last));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cpg_req_if #(.CW(CW)) req_if ();
  cpg_pt_if  #(.CW(CW)) pt_if ();

  circle_point_generator #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .pt_o  (pt_if.source)
  );

  circle_scoreboard sb = new();
  bit               burst;
  int unsigned      steps_sent;
  int unsigned      idle_cycles;
  int unsigned      stall_left;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input req_type_e kind, input logic [CW-1:0] cx,
                              input logic [CW-1:0] cy, input logic [CW-2:0] r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.center_x <= cx;
    req_if.center_y <= cy;
    req_if.radius   <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (sb.note_request(kind, cx, cy, r)) steps_sent++;
  endtask

  task automatic send_advance();
    send_request(REQ_ADVANCE, CW'($urandom), CW'($urandom), (CW-1)'($urandom));
  endtask

  // Start a circle and advance it until it finishes or max_adv advances are spent.
  task automatic run_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                            input logic [CW-2:0] r, input int unsigned max_adv);
    int unsigned n;
    n = 0;
    send_request(REQ_START, cx, cy, r);
    while (sb.running && n < max_adv) begin
      send_advance();
      n++;
    end
  endtask

  // Check point transfers, drive ready with random stalls, track idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pt_if.valid && pt_if.ready) begin
        sb.check_point(pt_if.point_x, pt_if.point_y, pt_if.last_point);
      end
      if ((pt_if.valid && pt_if.ready) || (req_if.valid && req_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (stall_left > 0) begin
        pt_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        pt_if.ready <= 1'b1;
        if (!burst && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned r;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_START;
    req_if.center_x = '0;
    req_if.center_y = '0;
    req_if.radius   = '0;
    pt_if.ready     = 1'b0;
    burst           = 1'b0;
    steps_sent      = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle advance, zero radius at both corners, extremes, restart mid-circle.
    send_advance();
    run_circle('0, '0, '0, 0);
    send_advance();
    run_circle('1, '1, '0, 0);
    run_circle('0, '1, 1, 4);
    send_advance();
    run_circle('1, '0, '1, 3);
    run_circle('0, '1, '1, 2);
    run_circle(CW'(1024), CW'(1024), 5, 10);
    send_advance();
    send_advance();
    run_circle(CW'(3), CW'(2044), 7, 2);

    // Random: mostly complete circles, some abandoned ones, some noise.
    while (steps_sent < StepTarget) begin
      burst = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        run_circle(CW'($urandom), CW'($urandom), (CW-1)'(r), 20);
        if ($urandom_range(0, 4) == 0) send_advance();
      end else if (roll < 85) begin
        run_circle(CW'($urandom), CW'($urandom), (CW-1)'($urandom), $urandom_range(0, 6));
      end else begin
        send_request(req_type_e'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                     (CW-1)'($urandom));
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
